@@ hw/rtl/lgv_pkg.sv @@
// ----------------------------------------------------------------------------
// lgv_pkg
// Shared widths, register map, reset values and types of the Legendre
// value-and-slope evaluator.
// ----------------------------------------------------------------------------
package lgv_pkg;

  // Fixed field widths.
  localparam int unsigned DATA_W  = 48;  // Q17.30 values
  localparam int unsigned X_W     = 32;  // Q1.30 sample and bounds
  localparam int unsigned ORDER_W = 6;
  localparam int unsigned MUL_A_W = 64;  // wide operand of the shared multiplier

  // Configuration port.
  localparam int unsigned APB_AW    = 6;
  localparam int unsigned APB_DW    = 64;
  localparam int unsigned REG_IDX_W = APB_AW - 3;

  localparam logic [REG_IDX_W-1:0] REG_POLY_ORDER = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_SCALE      = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_LOWER      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_UPPER      = 3'd4;

  // Defaults of the top-level parameters.
  localparam int unsigned MAX_ORDER_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF = 30;

  // Register reset values.
  localparam logic [ORDER_W-1:0]       RST_POLY_ORDER = '0;
  localparam logic signed [DATA_W-1:0] RST_SCALE      = 48'sd1073741824;
  localparam logic signed [DATA_W-1:0] RST_OFFSET     = '0;
  localparam logic signed [X_W-1:0]    RST_LOWER      = -32'sd1073741824;
  localparam logic signed [X_W-1:0]    RST_UPPER      = 32'sd1073741824;

  typedef struct packed {
    logic [ORDER_W-1:0]       poly_order;
    logic signed [DATA_W-1:0] scale;
    logic signed [DATA_W-1:0] offset;
    logic signed [X_W-1:0]    lower_bound;
    logic signed [X_W-1:0]    upper_bound;
  } lgv_cfg_t;

  // Status of the shared multiplier.
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } lgv_mul_sts_t;

endpackage

@@ hw/rtl/lgv_regs.sv @@
// ----------------------------------------------------------------------------
// lgv_regs
// Configuration register file behind the APB-style port.
// ----------------------------------------------------------------------------
module lgv_regs import lgv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output lgv_cfg_t          cfg_o
);

  logic [ORDER_W-1:0]       order_q;
  logic signed [DATA_W-1:0] scale_q;
  logic signed [DATA_W-1:0] offset_q;
  logic signed [X_W-1:0]    lower_q;
  logic signed [X_W-1:0]    upper_q;
  logic [REG_IDX_W-1:0]     idx;
  logic                     wr_en;

  assign idx    = paddr[APB_AW-1:3];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q  <= RST_POLY_ORDER;
      scale_q  <= RST_SCALE;
      offset_q <= RST_OFFSET;
      lower_q  <= RST_LOWER;
      upper_q  <= RST_UPPER;
    end else if (wr_en) begin
      case (idx)
        REG_POLY_ORDER: order_q  <= pwdata[ORDER_W-1:0];
        REG_SCALE:      scale_q  <= pwdata[DATA_W-1:0];
        REG_OFFSET:     offset_q <= pwdata[DATA_W-1:0];
        REG_LOWER:      lower_q  <= pwdata[X_W-1:0];
        REG_UPPER:      upper_q  <= pwdata[X_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_POLY_ORDER: prdata = APB_DW'(order_q);
      REG_SCALE:      prdata = APB_DW'(scale_q);
      REG_OFFSET:     prdata = APB_DW'(offset_q);
      REG_LOWER:      prdata = APB_DW'(lower_q);
      REG_UPPER:      prdata = APB_DW'(upper_q);
      default:        prdata = '0;
    endcase
  end

  assign cfg_o.poly_order  = order_q;
  assign cfg_o.scale       = scale_q;
  assign cfg_o.offset      = offset_q;
  assign cfg_o.lower_bound = lower_q;
  assign cfg_o.upper_bound = upper_q;

endmodule

@@ hw/rtl/lgv_fmul.sv @@
// ----------------------------------------------------------------------------
// lgv_fmul
// Shared fixed-point multiplier: a*b scaled by 2^-FRAC_BITS, rounded to
// nearest with ties away from zero, saturated to 48 bits. Built from four
// 32x32 partial products issued one per cycle.
// ----------------------------------------------------------------------------
module lgv_fmul import lgv_pkg::*; #(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic signed [MUL_A_W-1:0] op_a_i,
  input  logic signed [DATA_W-1:0]  op_b_i,
  output logic signed [DATA_W-1:0]  res_o,
  output lgv_mul_sts_t              sts_o
);

  localparam int unsigned HALF_W = 32;
  localparam int unsigned PP_W   = 2 * HALF_W;
  localparam int unsigned ACC_W  = 2 * MUL_A_W;

  localparam logic [2:0] STEP_FIRST   = 3'd0;
  localparam logic [2:0] STEP_LAST_PP = 3'd3;
  localparam logic [2:0] STEP_LAST_AC = 3'd4;
  localparam logic [2:0] STEP_ROUND   = 3'd5;

  localparam logic [DATA_W-1:0] LIM_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] LIM_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  logic                     busy_q;
  logic                     done_q;
  logic [2:0]               step_q;
  logic                     neg_q;
  logic [MUL_A_W-1:0]       ua_q;
  logic [DATA_W-1:0]        ub_q;
  logic [PP_W-1:0]          pp_q;
  logic [1:0]               pp_sh_q;
  logic [ACC_W-1:0]         acc_q;
  logic signed [DATA_W-1:0] res_q;
  logic                     ovf_q;

  logic [MUL_A_W-1:0]       ua_c;
  logic [DATA_W-1:0]        ub_c;
  logic [1:0]               pp_idx;
  logic [HALF_W-1:0]        a_chunk;
  logic [HALF_W-1:0]        b_chunk;
  logic [PP_W-1:0]          pp_d;
  logic [ACC_W-1:0]         pp_aligned;
  logic [ACC_W-1:0]         mag;
  logic [DATA_W-1:0]        lim;
  logic                     ovf_c;
  logic [DATA_W-1:0]        mag_c;
  logic [DATA_W-1:0]        res_c;

  assign ua_c = op_a_i[MUL_A_W-1] ? MUL_A_W'(-op_a_i) : MUL_A_W'(op_a_i);
  assign ub_c = op_b_i[DATA_W-1]  ? DATA_W'(-op_b_i)  : DATA_W'(op_b_i);

  // Partial product k multiplies chunk k[0] of a by chunk k[1] of b.
  assign pp_idx  = step_q[1:0];
  assign a_chunk = pp_idx[0] ? ua_q[MUL_A_W-1:HALF_W] : ua_q[HALF_W-1:0];
  assign b_chunk = pp_idx[1] ? HALF_W'(ub_q[DATA_W-1:HALF_W]) : ub_q[HALF_W-1:0];
  assign pp_d    = PP_W'(a_chunk) * PP_W'(b_chunk);

  always_comb begin
    case (pp_sh_q)
      2'd0:    pp_aligned = ACC_W'(pp_q);
      2'd1:    pp_aligned = ACC_W'(pp_q) << HALF_W;
      2'd2:    pp_aligned = ACC_W'(pp_q) << (2 * HALF_W);
      default: pp_aligned = '0;
    endcase
  end

  // The rounding constant is preloaded into the accumulator, so the last
  // step is just a shift and a range check.
  assign mag   = acc_q >> FRAC_BITS;
  assign lim   = neg_q ? LIM_NEG : LIM_POS;
  assign ovf_c = (|mag[ACC_W-1:DATA_W]) || (mag[DATA_W-1:0] > lim);
  assign mag_c = ovf_c ? lim : mag[DATA_W-1:0];
  assign res_c = neg_q ? DATA_W'(-mag_c) : mag_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= STEP_FIRST;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_FIRST;
      end else if (busy_q) begin
        step_q <= step_q + 3'd1;
        if (step_q == STEP_ROUND) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= op_a_i[MUL_A_W-1] ^ op_b_i[DATA_W-1];
      ua_q  <= ua_c;
      ub_q  <= ub_c;
      acc_q <= ACC_W'(1) << (FRAC_BITS - 1);
    end else if (busy_q) begin
      if (step_q <= STEP_LAST_PP) begin
        pp_q    <= pp_d;
        pp_sh_q <= 2'(pp_idx[0]) + 2'(pp_idx[1]);
      end
      if (step_q != STEP_FIRST && step_q <= STEP_LAST_AC) begin
        acc_q <= acc_q + pp_aligned;
      end
      if (step_q == STEP_ROUND) begin
        res_q <= res_c;
        ovf_q <= ovf_c;
      end
    end
  end

  assign res_o      = res_q;
  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign sts_o.ovf  = ovf_q;

endmodule

@@ hw/rtl/legendre_value_and_slope_eval.sv @@
// ----------------------------------------------------------------------------
// legendre_value_and_slope_eval
// Evaluates the Legendre polynomial P_n(q) and its slope at q = scale*x +
// offset with the three-term recurrence, in signed Q17.30, and flags samples
// outside the configured bounds.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake                   Payload
// in       in   in_valid_i / in_ready_o     x_value_i
// out      out  out_valid_o / out_ready_i   poly_value_o, poly_slope_o,
//                                           out_of_range_o, saturated_o
// cfg      in   psel, penable, pwrite       paddr, pwdata, prdata (pready high)
//
// A request of degree 0 or 1 needs only the scale product before its
// result; a higher degree adds one recurrence step per degree from 2 to n.
// Each recurrence step runs four products through the single 32x32
// multiplier, each with its issue and collect states, and the Y0, Y1,
// D0, D1 and D2 steps of the small coefficient multiply-accumulate. One request is in work at a time.
// A finished result waits in the output register while the next request is
// accepted; only a second finished result stalls the sequencer.
// Reset puts the configuration registers at their reset values; there is no clearing pass.
//
module legendre_value_and_slope_eval import lgv_pkg::*; #(
  parameter int unsigned MAX_ORDER = MAX_ORDER_DEF,
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic signed [X_W-1:0]    x_value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] poly_value_o,
  output logic signed [DATA_W-1:0] poly_slope_o,
  output logic                     out_of_range_o,
  output logic                     saturated_o
);

  localparam int unsigned IW     = $clog2(MAX_ORDER + 1);
  localparam int unsigned COEF_W = IW + 2;
  localparam int unsigned SUM_W  = DATA_W + COEF_W + 1;
  localparam int unsigned RCP_W  = FRAC_BITS;

  localparam logic signed [DATA_W-1:0] ONE     = DATA_W'(1) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_QMUL  = 4'd1;
  localparam logic [3:0] ST_TY_GO = 4'd2;
  localparam logic [3:0] ST_TY    = 4'd3;
  localparam logic [3:0] ST_TD_GO = 4'd4;
  localparam logic [3:0] ST_TD    = 4'd5;
  localparam logic [3:0] ST_Y0    = 4'd6;
  localparam logic [3:0] ST_Y1    = 4'd7;
  localparam logic [3:0] ST_NY_GO = 4'd8;
  localparam logic [3:0] ST_NY    = 4'd9;
  localparam logic [3:0] ST_D0    = 4'd10;
  localparam logic [3:0] ST_D1    = 4'd11;
  localparam logic [3:0] ST_D2    = 4'd12;
  localparam logic [3:0] ST_ND_GO = 4'd13;
  localparam logic [3:0] ST_ND    = 4'd14;
  localparam logic [3:0] ST_DONE  = 4'd15;

  lgv_cfg_t                   cfg;
  lgv_mul_sts_t               mul_sts;

  logic [3:0]                 state_q, state_d;
  logic                       out_valid_q;
  logic signed [DATA_W-1:0]   out_value_q, out_slope_q;
  logic                       out_oor_q, out_sat_q;

  logic                       oor_q, sat_q;
  logic [IW-1:0]              n_q, i_q;
  logic signed [DATA_W-1:0]   q_q, y_q, yp_q, dy_q, dyp_q, ty_q, td_q, ny_q;
  logic signed [SUM_W-1:0]    acc_q, acc_d;

  logic                       accept;
  logic                       out_load;
  logic                       mul_start;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [DATA_W-1:0]   mul_b;
  logic signed [DATA_W-1:0]   mul_res;

  logic signed [DATA_W:0]     q_sum;
  logic                       q_ovf;
  logic signed [DATA_W-1:0]   q_c;
  logic [IW-1:0]              n_c;
  logic                       oor_c;

  logic signed [COEF_W-1:0]   c2, nc4;
  logic signed [COEF_W-1:0]   mac_coef;
  logic signed [DATA_W-1:0]   mac_opnd;
  logic                       mac_clr;
  logic signed [SUM_W-1:0]    mac_prod;

  logic [RCP_W-1:0]           rcp_tab [MAX_ORDER+1];
  logic [RCP_W-1:0]           rcp_sel;

  lgv_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lgv_fmul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_fmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .op_a_i  (mul_a),
    .op_b_i  (mul_b),
    .res_o   (mul_res),
    .sts_o   (mul_sts)
  );

  // Reciprocal table, round(2^FRAC_BITS / i); entries below two are unused.
  for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_rcp
    if (g < 2) begin : g_unused
      assign rcp_tab[g] = '0;
    end else begin : g_entry
      localparam logic [63:0] RV = ((64'd1 << FRAC_BITS) + 64'(g / 2)) / 64'(g);
      assign rcp_tab[g] = RV[RCP_W-1:0];
    end
  end

  assign rcp_sel = rcp_tab[i_q];

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign oor_c = (x_value_i < cfg.lower_bound) || (x_value_i > cfg.upper_bound);
  assign n_c   = (32'(cfg.poly_order) > MAX_ORDER) ? IW'(MAX_ORDER)
                                                   : IW'(cfg.poly_order);

  // q = scale*x + offset, saturated.
  assign q_sum = {mul_res[DATA_W-1], mul_res} + {cfg.offset[DATA_W-1], cfg.offset};
  assign q_ovf = q_sum[DATA_W] ^ q_sum[DATA_W-1];
  assign q_c   = q_ovf ? (q_sum[DATA_W] ? SAT_NEG : SAT_POS) : q_sum[DATA_W-1:0];

  // Coefficients 2i-1 and -(i-1) of the recurrence.
  assign c2  = COEF_W'({i_q, 1'b0}) - COEF_W'(1);
  assign nc4 = COEF_W'(1) - COEF_W'(i_q);

  always_comb begin
    mac_clr  = 1'b1;
    mac_coef = c2;
    mac_opnd = ty_q;
    case (state_q)
      ST_Y0: begin
        mac_clr  = 1'b1;
        mac_coef = c2;
        mac_opnd = ty_q;
      end
      ST_Y1: begin
        mac_clr  = 1'b0;
        mac_coef = nc4;
        mac_opnd = yp_q;
      end
      ST_D0: begin
        mac_clr  = 1'b1;
        mac_coef = c2;
        mac_opnd = td_q;
      end
      ST_D1: begin
        mac_clr  = 1'b0;
        mac_coef = nc4;
        mac_opnd = dyp_q;
      end
      ST_D2: begin
        mac_clr  = 1'b0;
        mac_coef = c2;
        mac_opnd = y_q;
      end
      default: begin
      end
    endcase
  end

  assign mac_prod = SUM_W'(mac_coef) * SUM_W'(mac_opnd);
  assign acc_d    = (mac_clr ? SUM_W'(0) : acc_q) + mac_prod;

  always_comb begin
    case (state_q)
      ST_IDLE: begin
        mul_a = MUL_A_W'(cfg.scale);
        mul_b = DATA_W'(x_value_i);
      end
      ST_TD_GO: begin
        mul_a = MUL_A_W'(q_q);
        mul_b = dy_q;
      end
      ST_NY_GO, ST_ND_GO: begin
        mul_a = MUL_A_W'(acc_q);
        mul_b = DATA_W'(rcp_sel);
      end
      default: begin
        mul_a = MUL_A_W'(q_q);
        mul_b = y_q;
      end
    endcase
  end

  assign mul_start = accept || (state_q == ST_TY_GO) || (state_q == ST_TD_GO) ||
                     (state_q == ST_NY_GO) || (state_q == ST_ND_GO);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = ST_QMUL;
      ST_QMUL: begin
        if (mul_sts.done) begin
          state_d = (n_q < IW'(2)) ? ST_DONE : ST_TY_GO;
        end
      end
      ST_TY_GO: state_d = ST_TY;
      ST_TY:    if (mul_sts.done) state_d = ST_TD_GO;
      ST_TD_GO: state_d = ST_TD;
      ST_TD:    if (mul_sts.done) state_d = ST_Y0;
      ST_Y0:    state_d = ST_Y1;
      ST_Y1:    state_d = ST_NY_GO;
      ST_NY_GO: state_d = ST_NY;
      ST_NY:    if (mul_sts.done) state_d = ST_D0;
      ST_D0:    state_d = ST_D1;
      ST_D1:    state_d = ST_D2;
      ST_D2:    state_d = ST_ND_GO;
      ST_ND_GO: state_d = ST_ND;
      ST_ND: begin
        if (mul_sts.done) begin
          state_d = (i_q == n_q) ? ST_DONE : ST_TY_GO;
        end
      end
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          oor_q <= oor_c;
          sat_q <= 1'b0;
          n_q   <= n_c;
        end
      end
      ST_QMUL: begin
        if (mul_sts.done) begin
          q_q   <= q_c;
          sat_q <= sat_q | mul_sts.ovf | q_ovf;
          // Degree zero gives value 1.0 and slope 0; otherwise start at P_1.
          y_q   <= (n_q == '0) ? ONE : q_c;
          dy_q  <= (n_q == '0) ? '0 : ONE;
          yp_q  <= ONE;
          dyp_q <= '0;
          i_q   <= IW'(2);
        end
      end
      ST_TY: begin
        if (mul_sts.done) begin
          ty_q  <= mul_res;
          sat_q <= sat_q | mul_sts.ovf;
        end
      end
      ST_TD: begin
        if (mul_sts.done) begin
          td_q  <= mul_res;
          sat_q <= sat_q | mul_sts.ovf;
        end
      end
      ST_Y0, ST_Y1, ST_D0, ST_D1, ST_D2: begin
        acc_q <= acc_d;
      end
      ST_NY: begin
        if (mul_sts.done) begin
          ny_q  <= mul_res;
          sat_q <= sat_q | mul_sts.ovf;
        end
      end
      ST_ND: begin
        if (mul_sts.done) begin
          y_q   <= ny_q;
          yp_q  <= y_q;
          dy_q  <= mul_res;
          dyp_q <= dy_q;
          sat_q <= sat_q | mul_sts.ovf;
          if (i_q != n_q) begin
            i_q <= i_q + IW'(1);
          end
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_value_q <= y_q;
          out_slope_q <= dy_q;
          out_oor_q   <= oor_q;
          out_sat_q   <= sat_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign poly_value_o   = out_value_q;
  assign poly_slope_o   = out_slope_q;
  assign out_of_range_o = out_oor_q;
  assign saturated_o    = out_sat_q;

  // The multiplier is only started when it is free.
  a_mul_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_sts.busy)
    else $error("multiplier started while busy");

  // A finished product always arrives in a state that collects it.
  a_mul_collect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_sts.done |-> (state_q == ST_QMUL || state_q == ST_TY || state_q == ST_TD ||
                      state_q == ST_NY || state_q == ST_ND))
    else $error("product finished outside a collecting state");

  // Each recurrence step works on a degree between two and the target degree.
  a_loop_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TY_GO) |-> (i_q >= IW'(2) && i_q <= n_q))
    else $error("recurrence index out of range");

  // A finished result waits while the previous one is still held.
  a_done_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_o && !out_ready_i) |=>
      (state_q == ST_DONE && $stable(poly_value_o) && $stable(poly_slope_o)))
    else $error("pending result overwritten");

endmodule
